@@ hw/rtl/wats_pkg.sv @@
// Package for the weekly alarm table scheduler: sizes, codes, entry and
// tick-context layouts, state encoding and small arithmetic helpers.
// Depends on nothing; wats_min_div, wats_entry_eval, the top level and the testbench import it.
package wats_pkg;

   // Table size and derived index width
   localparam int SLOTS  = 16;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Time and minute-number widths (32-bit seconds / 60 needs 27 bits)
   localparam int TIME_W = 32;
   localparam int MIN_W  = 27;

   // Reciprocal of 60: floor(2^37 / 60); quotient estimate is low by at most one
   localparam logic [TIME_W-1:0] DIV60_MUL   = 32'd2290649224;
   localparam int                DIV60_SHIFT = 37;
   localparam logic [TIME_W-1:0] SEC_PER_MIN = 32'd60;

   // Request opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // Weekday code that matches any day
   localparam logic [3:0] WEEKDAY_ANY = 4'b1111;

   // Settings of one alarm entry (enable bit lives in flip-flops)
   typedef struct packed {
      logic [3:0]  weekday;
      logic [5:0]  hour;
      logic [5:0]  minute;
      logic [15:0] interval_min;
      logic [15:0] delay_min;
   } entry_settings_type;

   // One word of the table memory: settings plus last fire time
   typedef struct packed {
      entry_settings_type  settings;
      logic [TIME_W-1:0]   last_fire;
   } entry_word_type;

   localparam int WORD_W = $bits(entry_word_type);

   // Per-tick context shared by the sequencer and the entry evaluator
   typedef struct packed {
      logic [TIME_W-1:0] now;
      logic [TIME_W:0]   since;    // now - start, two's complement
      logic [TIME_W-1:0] base_lo;  // first second of the current minute
      logic [TIME_W:0]   base_hi;  // last second of the current minute
      logic [2:0]        weekday;
      logic [4:0]        hour;
      logic [5:0]        minute;
   } tick_ctx_type;

   // Result of the seconds-to-minute unit
   typedef struct packed {
      logic              valid;
      logic [MIN_W-1:0]  quot;
      logic [TIME_W-1:0] base;
   } div_result_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_WALK,
      ST_FINISH
   } state_type;

   // Minutes to seconds for a 16-bit count: v * 64 - v * 4
   function automatic logic [22:0] times60(input logic [15:0] v);
      logic [22:0] w;
      w = {7'b0, v};
      return (w << 6) - (w << 2);
   endfunction

endpackage

@@ hw/rtl/wats_if.sv @@
// Channel interfaces of the weekly alarm table scheduler: request, result
// and configuration write channels, each with valid/ready handshake.
// Depends on nothing.

interface wats_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic [3:0]         slot;
   logic               entry_on;
   logic signed [3:0]  entry_weekday;
   logic signed [5:0]  entry_hour;
   logic [5:0]         entry_minute;
   logic [15:0]        entry_interval_min;
   logic [15:0]        entry_delay_min;
   logic [31:0]        now_seconds;
   logic [2:0]         now_weekday;
   logic [4:0]         now_hour;
   logic [5:0]         now_minute;

   modport source (
      output valid, op, slot, entry_on, entry_weekday, entry_hour, entry_minute,
             entry_interval_min, entry_delay_min, now_seconds, now_weekday,
             now_hour, now_minute,
      input  ready
   );
   modport sink (
      input  valid, op, slot, entry_on, entry_weekday, entry_hour, entry_minute,
             entry_interval_min, entry_delay_min, now_seconds, now_weekday,
             now_hour, now_minute,
      output ready
   );
endinterface

interface wats_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] fired_slot;
   logic       last;

   modport source (output valid, fired_slot, last, input ready);
   modport sink   (input valid, fired_slot, last, output ready);
endinterface

interface wats_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] start_time_seconds;

   modport source (output valid, start_time_seconds, input ready);
   modport sink   (input valid, start_time_seconds, output ready);
endinterface

@@ hw/rtl/wats_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. Depends on nothing.
module wats_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port: hold the last word when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/wats_min_div.sv @@
// Seconds-to-minute unit: two-stage reciprocal multiply by 1/60 with a
// final one-step correction. Depends on wats_pkg.
module wats_min_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [wats_pkg::TIME_W-1:0] dividend,
   output wats_pkg::div_result_type    div_res
);
   import wats_pkg::*;

   logic                  v1_ff;
   logic [TIME_W-1:0]     num1_ff;
   logic [2*TIME_W-1:0]   prod_ff;
   logic                  v2_ff;
   logic [TIME_W-1:0]     num2_ff;
   logic [MIN_W-1:0]      q0_ff;
   logic [TIME_W-1:0]     qx60_ff;
   logic [MIN_W-1:0]      q0_in;
   logic [TIME_W:0]       qx60_wide;
   logic [TIME_W-1:0]     rem;

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
   end

   // Stage 1: multiply by the reciprocal
   always_ff @(posedge clock) begin
      num1_ff <= dividend;
      prod_ff <= (2*TIME_W)'(dividend) * (2*TIME_W)'(DIV60_MUL);
   end

   // Stage 2: quotient estimate and its multiple of 60
   assign q0_in     = prod_ff[DIV60_SHIFT +: MIN_W];
   assign qx60_wide = ((TIME_W+1)'(q0_in) << 6) - ((TIME_W+1)'(q0_in) << 2);

   always_ff @(posedge clock) begin
      num2_ff <= num1_ff;
      q0_ff   <= q0_in;
      qx60_ff <= qx60_wide[TIME_W-1:0];
   end

   // Correct an estimate that is one low
   assign rem = num2_ff - qx60_ff;

   always_comb begin
      div_res.valid = v2_ff;
      if (rem >= SEC_PER_MIN) begin
         div_res.quot = q0_ff + MIN_W'(1);
         div_res.base = qx60_ff + SEC_PER_MIN;
      end else begin
         div_res.quot = q0_ff;
         div_res.base = qx60_ff;
      end
   end

endmodule

@@ hw/rtl/wats_entry_eval.sv @@
// Fire decision for one table entry against the current tick: startup
// delay, weekday, interval and one-shot rules. Depends on wats_pkg.
module wats_entry_eval (
   input  logic                     entry_on,
   input  wats_pkg::entry_word_type word,
   input  wats_pkg::tick_ctx_type   ctx,
   output logic                     fire
);
   import wats_pkg::*;

   entry_settings_type  s;
   logic [TIME_W-1:0]   lft;
   logic                never;
   logic [22:0]         delay_x60;
   logic [22:0]         interval_x60;
   logic                delay_block;
   logic                wd_ok;
   logic                hour_set;
   logic [5:0]          now_hour6;
   logic                first_ok;
   logic signed [TIME_W:0] elapsed;
   logic                rep_ok;
   logic                ivl_fire;
   logic                time_match;
   logic                same_min;
   logic                shot_fire;

   assign s     = word.settings;
   assign lft   = word.last_fire;
   assign never = (lft == '0);

   assign delay_x60    = times60(s.delay_min);
   assign interval_x60 = times60(s.interval_min);

   // Startup delay applies until the first fire
   assign delay_block = (s.delay_min != 16'd0) && never &&
                        ($signed(ctx.since) < $signed({10'b0, delay_x60}));

   // Weekday filter
   assign wd_ok = (s.weekday == WEEKDAY_ANY) ||
                  ($signed(s.weekday) == $signed({1'b0, ctx.weekday}));

   // Interval mode, first run: not before hour:minute when an hour is set
   assign hour_set  = !s.hour[5];
   assign now_hour6 = {1'b0, ctx.hour};
   assign first_ok  = !(hour_set && (now_hour6 < s.hour)) &&
                      !(hour_set && (now_hour6 == s.hour) && (ctx.minute < s.minute));

   // Interval mode, later runs: once the interval has gone by
   assign elapsed  = $signed({1'b0, ctx.now}) - $signed({1'b0, lft});
   assign rep_ok   = elapsed >= $signed({10'b0, interval_x60});
   assign ivl_fire = never ? first_ok : rep_ok;

   // One-shot mode: exact hour:minute, not again within this minute
   assign time_match = ($signed(s.hour) == $signed({1'b0, ctx.hour})) &&
                       (s.minute == ctx.minute);
   assign same_min   = ({1'b0, lft} >= {1'b0, ctx.base_lo}) && ({1'b0, lft} <= ctx.base_hi);
   assign shot_fire  = time_match && !same_min;

   assign fire = entry_on && !delay_block && wd_ok &&
                 ((s.interval_min != 16'd0) ? ivl_fire : shot_fire);

endmodule

@@ hw/rtl/weekly_alarm_table_scheduler_top.sv @@
// Weekly alarm table scheduler, top level: request sequencer, table memory,
// minute unit and entry evaluator. Depends on wats_pkg, wats_if, wats_ram,
// wats_min_div and wats_entry_eval.
//
// A write request loads one table slot and clears its last fire time.
// A tick request first runs the seconds-to-minute unit; a tick in the
// minute already checked, or with no entry enabled, ends there. Otherwise
// the sequencer walks the table memory one entry per cycle, save while a
// pending fire waits for a busy result channel, through its read and write
// ports, then releases the last fire and returns to idle; only there is the
// next request taken. Fires come out in slot order, one result per fire,
// the last of a tick flagged by last. Entry enable bits sit in flip-flops
// that reset clears; the memory needs no clearing pass. The configuration
// write channel is always ready.
module weekly_alarm_table_scheduler_top (
   input  logic     clock,
   input  logic     reset,
   wats_req_if.sink   req_ch,
   wats_rsp_if.source rsp_ch,
   wats_csr_if.sink   csr_ch
);
   import wats_pkg::*;

   state_type          state_ff, state_in;
   tick_ctx_type       ctx_ff, ctx_in;
   logic [TIME_W-1:0]  start_ff;
   logic [SLOTS-1:0]   on_ff, on_in;
   logic [MIN_W-1:0]   lcm_ff, lcm_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic               pend_v_ff, pend_v_in;
   logic [SLOT_W-1:0]  pend_slot_ff, pend_slot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         rsp_slot_ff;
   logic               rsp_last_ff;

   logic               req_accept;
   logic               slot_ok;
   logic [SLOT_W-1:0]  slot_idx;
   logic               out_free;
   logic               rsp_load;
   logic               rsp_load_last;
   logic               div_start;
   div_result_type     div_res;
   logic               fire;
   logic               stall;
   logic               last_idx;

   logic               ram_we;
   logic [SLOT_W-1:0]  ram_waddr;
   entry_word_type     ram_wword;
   logic               ram_re;
   logic [SLOT_W-1:0]  ram_raddr;
   logic [WORD_W-1:0]  ram_rdata;
   entry_word_type     ram_word;

   // Handshake helpers
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign slot_idx     = SLOT_W'(req_ch.slot);
   assign slot_ok      = (32'(req_ch.slot) < SLOTS);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign last_idx     = (idx_ff == SLOT_W'(SLOTS - 1));
   assign stall        = fire && pend_v_ff && !out_free;

   // Table memory
   wats_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wword),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign ram_word = entry_word_type'(ram_rdata);

   // Seconds-to-minute unit
   wats_min_div u_min_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_ch.now_seconds),
      .div_res  (div_res)
   );

   // Entry evaluator
   wats_entry_eval u_eval (
      .entry_on (on_ff[idx_ff]),
      .word     (ram_word),
      .ctx      (ctx_ff),
      .fire     (fire)
   );

   // Start time register
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
      end else if (csr_ch.valid) begin
         start_ff <= csr_ch.start_time_seconds;
      end
   end

   // State register and control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         on_ff     <= '0;
         lcm_ff    <= '0;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         on_ff     <= on_in;
         lcm_ff    <= lcm_in;
         pend_v_ff <= pend_v_in;
      end
   end

   // Tick context, walk index and pending fire
   always_ff @(posedge clock) begin
      ctx_ff       <= ctx_in;
      idx_ff       <= idx_in;
      pend_slot_ff <= pend_slot_in;
   end

   // Next state, memory control and result loading
   always_comb begin
      state_in      = state_ff;
      ctx_in        = ctx_ff;
      on_in         = on_ff;
      lcm_in        = lcm_ff;
      idx_in        = idx_ff;
      pend_v_in     = pend_v_ff;
      pend_slot_in  = pend_slot_ff;
      rsp_load      = 1'b0;
      rsp_load_last = 1'b0;
      div_start     = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wword     = ram_word;
      ram_re        = 1'b0;
      ram_raddr     = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_ch.op == OP_WRITE) begin
                  // Load one slot and clear its last fire time
                  if (slot_ok) begin
                     ram_we                          = 1'b1;
                     ram_waddr                       = slot_idx;
                     ram_wword.settings.weekday      = req_ch.entry_weekday;
                     ram_wword.settings.hour         = req_ch.entry_hour;
                     ram_wword.settings.minute       = req_ch.entry_minute;
                     ram_wword.settings.interval_min = req_ch.entry_interval_min;
                     ram_wword.settings.delay_min    = req_ch.entry_delay_min;
                     ram_wword.last_fire             = '0;
                     on_in[slot_idx]                 = req_ch.entry_on;
                  end
               end else begin
                  // Capture the tick and start the minute computation
                  div_start      = 1'b1;
                  ctx_in.now     = req_ch.now_seconds;
                  ctx_in.since   = {1'b0, req_ch.now_seconds} - {1'b0, start_ff};
                  ctx_in.weekday = req_ch.now_weekday;
                  ctx_in.hour    = req_ch.now_hour;
                  ctx_in.minute  = req_ch.now_minute;
                  state_in       = ST_DIV;
               end
            end
         end

         ST_DIV: begin
            if (div_res.valid) begin
               // Drop ticks in the checked minute or with an empty table
               if ((|on_ff) && (div_res.quot != lcm_ff)) begin
                  lcm_in         = div_res.quot;
                  ctx_in.base_lo = div_res.base;
                  ctx_in.base_hi = {1'b0, div_res.base} + (TIME_W+1)'(SEC_PER_MIN - 32'd1);
                  idx_in         = '0;
                  ram_re         = 1'b1;
                  ram_raddr      = '0;
                  state_in       = ST_WALK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_WALK: begin
            // Hold the read word while a pending fire waits for the output
            if (!stall) begin
               if (fire) begin
                  ram_we              = 1'b1;
                  ram_waddr           = idx_ff;
                  ram_wword.last_fire = ctx_ff.now;
                  if (pend_v_ff) begin
                     rsp_load = 1'b1;
                  end
                  pend_v_in    = 1'b1;
                  pend_slot_in = idx_ff;
               end
               if (last_idx) begin
                  state_in = ST_FINISH;
               end else begin
                  idx_in    = idx_ff + SLOT_W'(1);
                  ram_re    = 1'b1;
                  ram_raddr = idx_ff + SLOT_W'(1);
               end
            end
         end

         ST_FINISH: begin
            // Release the final fire of the tick with last set
            if (!pend_v_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_load      = 1'b1;
               rsp_load_last = 1'b1;
               pend_v_in     = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result output register
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_slot_ff <= 4'(pend_slot_ff);
         rsp_last_ff <= rsp_load_last;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.fired_slot = rsp_slot_ff;
   assign rsp_ch.last       = rsp_last_ff;

`ifndef SYNTH
   // No fire stays pending once the sequencer is back in idle
   a_idle_no_pending: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_v_ff
   ) else $error("pending fire left over in idle");

   // A result is never loaded over one that is still waiting
   a_no_overwrite: assert property (
      @(posedge clock) disable iff (reset)
      rsp_load |-> out_free
   ) else $error("result register overwritten");

   // A stalled walk keeps its entry and its place in the table
   a_stall_holds: assert property (
      @(posedge clock) disable iff (reset)
      ((state_ff == ST_WALK) && stall) |=> ((state_ff == ST_WALK) && $stable(idx_ff))
   ) else $error("walk advanced during stall");
`endif

endmodule

@@ bench/tb_weekly_alarm_table_scheduler_top.sv @@
// Testbench for weekly_alarm_table_scheduler_top: directed and random requests
// checked against an alarm table predictor, fire by fire, in slot order.
// Depends on wats_pkg, wats_if and the scheduler RTL.
module tb_weekly_alarm_table_scheduler_top;
   import wats_pkg::*;

   localparam int ITEMS_PER_PHASE = 39;
   localparam int DRAIN_CYCLES    = 40;
   localparam int DRAIN_GUARD     = 50000;
   localparam int RUN_LIMIT       = 5000000;

   // One request as the sender sees it
   typedef struct {
      logic               op;
      logic [3:0]         slot;
      logic               entry_on;
      logic signed [3:0]  entry_weekday;
      logic signed [5:0]  entry_hour;
      logic [5:0]         entry_minute;
      logic [15:0]        entry_interval_min;
      logic [15:0]        entry_delay_min;
      logic [31:0]        now_seconds;
      logic [2:0]         now_weekday;
      logic [4:0]         now_hour;
      logic [5:0]         now_minute;
   } alarm_request_type;

   // Predictor copy of one table entry
   typedef struct {
      bit                 on;
      logic signed [3:0]  weekday;
      logic signed [5:0]  hour;
      logic [5:0]         minute;
      logic [15:0]        interval_min;
      logic [15:0]        delay_min;
   } alarm_entry_type;

   typedef struct packed {
      logic [3:0] slot;
      logic       last;
   } alarm_fire_type;

   logic clock = 1'b0;
   logic reset;

   wats_req_if req_if ();
   wats_rsp_if rsp_if ();
   wats_csr_if csr_if ();

   weekly_alarm_table_scheduler_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // Predictor state
   alarm_entry_type  alarm_table [SLOTS];
   logic [31:0]      fire_time [SLOTS];
   logic [31:0]      checked_minute = '0;
   logic [31:0]      start_time_model = '0;
   alarm_fire_type   pending_fires [$];

   alarm_request_type accepted_request;
   alarm_fire_type    expected_fire;
   int                mismatch_count = 0;
   int                sender_idle_pct = 0;
   int                receiver_stall_pct = 0;
   logic [31:0]       wall_clock;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(RUN_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Compute the fires that one accepted request causes
   function automatic void predict_request(input alarm_request_type r);
      alarm_entry_type ent;
      alarm_fire_type  fire_item;
      logic [31:0]     cur_min;
      longint          since_start;
      longint          elapsed;
      int              wday, hr, mn, ent_wday, ent_hour, idx;
      bit              any_on, fire;
      logic [3:0]      fired_slots [$];
      if (r.op == OP_WRITE) begin
         if (int'(r.slot) < SLOTS) begin
            alarm_table[r.slot] = '{on: r.entry_on, weekday: r.entry_weekday,
                                    hour: r.entry_hour, minute: r.entry_minute,
                                    interval_min: r.entry_interval_min,
                                    delay_min: r.entry_delay_min};
            fire_time[r.slot] = '0;
         end
         return;
      end
      cur_min = r.now_seconds / SEC_PER_MIN;
      any_on = 1'b0;
      for (idx = 0; idx < SLOTS; idx++)
         if (alarm_table[idx].on) any_on = 1'b1;
      // Drop ticks with an empty table or in the minute already checked
      if (!any_on || cur_min == checked_minute) return;
      checked_minute = cur_min;
      wday = int'(r.now_weekday);
      hr   = int'(r.now_hour);
      mn   = int'(r.now_minute);
      for (idx = 0; idx < SLOTS; idx++) begin
         ent = alarm_table[idx];
         fire = 1'b0;
         if (!ent.on) continue;
         ent_wday = int'(ent.weekday);
         ent_hour = int'(ent.hour);
         // Hold off until the startup delay has passed, signed against start
         if (ent.delay_min != 0 && fire_time[idx] == 0) begin
            since_start = longint'(r.now_seconds) - longint'(start_time_model);
            if (since_start < longint'(ent.delay_min) * longint'(SEC_PER_MIN)) continue;
         end
         if (ent_wday != -1 && ent_wday != wday) continue;
         if (ent.interval_min != 0) begin
            if (fire_time[idx] == 0) begin
               if (ent_hour >= 0 && hr < ent_hour) continue;
               if (ent_hour >= 0 && hr == ent_hour && mn < int'(ent.minute)) continue;
               fire = 1'b1;
            end else begin
               elapsed = longint'(r.now_seconds) - longint'(fire_time[idx]);
               fire = (elapsed >= longint'(ent.interval_min) * longint'(SEC_PER_MIN));
            end
         end else begin
            if (ent_hour != hr || int'(ent.minute) != mn) continue;
            if (fire_time[idx] / SEC_PER_MIN == cur_min) continue;
            fire = 1'b1;
         end
         if (fire) begin
            fire_time[idx] = r.now_seconds;
            fired_slots = {fired_slots, idx[3:0]};
         end
      end
      foreach (fired_slots[k]) begin
         fire_item.slot = fired_slots[k];
         fire_item.last = (k == fired_slots.size() - 1);
         pending_fires  = {pending_fires, fire_item};
      end
   endfunction

   // Sample both channels and the register write at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_fires.size() == 0) begin
               report_mismatch($sformatf("unexpected fire of slot %0d", rsp_if.fired_slot));
            end else begin
               expected_fire = pending_fires.pop_front();
               if (rsp_if.fired_slot !== expected_fire.slot)
                  report_mismatch($sformatf("fired_slot %0d, expected %0d",
                                            rsp_if.fired_slot, expected_fire.slot));
               if (rsp_if.last !== expected_fire.last)
                  report_mismatch($sformatf("last %b on slot %0d, expected %b",
                                            rsp_if.last, expected_fire.slot,
                                            expected_fire.last));
            end
         end
         if (req_if.valid && req_if.ready) begin
            accepted_request.op                 = req_if.op;
            accepted_request.slot               = req_if.slot;
            accepted_request.entry_on           = req_if.entry_on;
            accepted_request.entry_weekday      = req_if.entry_weekday;
            accepted_request.entry_hour         = req_if.entry_hour;
            accepted_request.entry_minute       = req_if.entry_minute;
            accepted_request.entry_interval_min = req_if.entry_interval_min;
            accepted_request.entry_delay_min    = req_if.entry_delay_min;
            accepted_request.now_seconds        = req_if.now_seconds;
            accepted_request.now_weekday        = req_if.now_weekday;
            accepted_request.now_hour           = req_if.now_hour;
            accepted_request.now_minute         = req_if.now_minute;
            predict_request(accepted_request);
         end
         if (csr_if.valid && csr_if.ready)
            start_time_model = csr_if.start_time_seconds;
      end
   end

   // Stall the result channel at random
   always @(negedge clock)
      rsp_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

   function automatic alarm_request_type make_write(input int slot, input bit on, input int wd,
                                                    input int hr, input int mn, input int iv,
                                                    input int dl);
      alarm_request_type r;
      r.op                 = OP_WRITE;
      r.slot               = 4'(slot);
      r.entry_on           = on;
      r.entry_weekday      = 4'(wd);
      r.entry_hour         = 6'(hr);
      r.entry_minute       = 6'(mn);
      r.entry_interval_min = 16'(iv);
      r.entry_delay_min    = 16'(dl);
      r.now_seconds        = $urandom;
      r.now_weekday        = 3'($urandom_range(0, 6));
      r.now_hour           = 5'($urandom_range(0, 23));
      r.now_minute         = 6'($urandom_range(0, 59));
      return r;
   endfunction

   function automatic alarm_request_type make_tick(input logic [31:0] now, input int wd,
                                                   input int hr, input int mn);
      alarm_request_type r;
      r.op                 = OP_TICK;
      r.slot               = 4'($urandom_range(0, 15));
      r.entry_on           = 1'($urandom_range(0, 1));
      r.entry_weekday      = 4'(int'($urandom_range(0, 7)) - 1);
      r.entry_hour         = 6'(int'($urandom_range(0, 24)) - 1);
      r.entry_minute       = 6'($urandom_range(0, 59));
      r.entry_interval_min = 16'($urandom);
      r.entry_delay_min    = 16'($urandom);
      r.now_seconds        = now;
      r.now_weekday        = 3'(wd);
      r.now_hour           = 5'(hr);
      r.now_minute         = 6'(mn);
      return r;
   endfunction

   // Present one request, idling first at the configured rate
   task automatic send_request(input alarm_request_type item);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid              <= 1'b1;
      req_if.op                 <= item.op;
      req_if.slot               <= item.slot;
      req_if.entry_on           <= item.entry_on;
      req_if.entry_weekday      <= item.entry_weekday;
      req_if.entry_hour         <= item.entry_hour;
      req_if.entry_minute       <= item.entry_minute;
      req_if.entry_interval_min <= item.entry_interval_min;
      req_if.entry_delay_min    <= item.entry_delay_min;
      req_if.now_seconds        <= item.now_seconds;
      req_if.now_weekday        <= item.now_weekday;
      req_if.now_hour           <= item.now_hour;
      req_if.now_minute         <= item.now_minute;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // Drop the request valid, wait for every fire, then let the block settle
   task automatic wait_until_drained();
      int guard;
      guard = 0;
      req_if.valid <= 1'b0;
      do begin
         @(negedge clock);
         guard++;
      end while (pending_fires.size() != 0 && guard < DRAIN_GUARD);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_start_time(input logic [31:0] value);
      csr_if.valid              <= 1'b1;
      csr_if.start_time_seconds <= value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Ticks with no entry enabled, before and after a disabled write
   task automatic test_empty_table();
      send_request(make_tick(32'd120, 1, 0, 2));
      send_request(make_write(3, 1'b0, -1, 10, 30, 0, 0));
      send_request(make_tick(32'd180, 1, 0, 3));
   endtask

   // Exact-time alarms, odd weekday and unset hour codes, repeats in a minute
   task automatic test_one_shot_alarms();
      send_request(make_write(0, 1'b1, -1, 10, 30, 0, 0));
      send_request(make_write(15, 1'b1, 6, 23, 59, 0, 0));
      send_request(make_write(7, 1'b1, -1, -1, 0, 0, 0));
      send_request(make_write(9, 1'b1, 7, 10, 30, 0, 0));
      send_request(make_tick(32'd1000020, 2, 10, 30));
      send_request(make_tick(32'd1000059, 2, 10, 30));
      send_request(make_tick(32'd1000080, 6, 23, 59));
      send_request(make_tick(32'd1000140, 6, 23, 59));
      send_request(make_tick(32'hFFFF_FFFF, 0, 0, 0));
   endtask

   // Repeating alarms with the extremes of interval and startup delay
   task automatic test_interval_alarms();
      send_request(make_write(1, 1'b1, -1, -1, 0, 1, 0));
      send_request(make_write(2, 1'b1, 3, 12, 0, 65535, 0));
      send_request(make_write(4, 1'b1, -1, 5, 59, 2, 65535));
      send_request(make_tick(32'd2000000, 3, 12, 0));
      send_request(make_tick(32'd2000060, 3, 12, 1));
      send_request(make_tick(32'd4000000, 3, 4, 0));
      send_request(make_tick(32'd4000200, 3, 5, 59));
   endtask

   // Start time above the current time keeps delayed entries quiet
   task automatic test_start_after_now();
      wait_until_drained();
      write_start_time(32'hFFFF_FFFF);
      send_request(make_write(4, 1'b1, -1, -1, 0, 1, 1));
      send_request(make_tick(32'd4001000, 3, 6, 0));
   endtask

   // A fire recorded at second zero still counts as never fired
   task automatic test_fire_at_time_zero();
      wait_until_drained();
      write_start_time(32'd0);
      send_request(make_tick(32'd0, 0, 0, 0));
      send_request(make_tick(32'd60, 0, 0, 1));
   endtask

   // Mostly calendar-consistent minute ticks with fresh entries near the
   // current time, plus noise: repeats, jumps, time going back, odd fields
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [31:0] start_setting);
      int          items, pick;
      int          cal_wday, cal_hour, cal_min;
      int          wd, hr, mn, iv, dl;
      wait_until_drained();
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      write_start_time(start_setting);
      items = 0;
      while (items < ITEMS_PER_PHASE) begin
         cal_min  = int'((wall_clock / 60) % 60);
         cal_hour = int'((wall_clock / 3600) % 24);
         cal_wday = int'((wall_clock / 86400 + 4) % 7);
         if ($urandom_range(0, 99) < 25) begin
            pick = $urandom_range(0, 99);
            wd = (pick < 40) ? -1 : (pick < 80) ? cal_wday : int'($urandom_range(0, 6));
            pick = $urandom_range(0, 99);
            hr = (pick < 15) ? -1 : (pick < 65) ? cal_hour : int'($urandom_range(0, 23));
            mn = ($urandom_range(0, 99) < 60) ? (cal_min + int'($urandom_range(0, 3))) % 60
                                              : int'($urandom_range(0, 59));
            pick = $urandom_range(0, 99);
            iv = (pick < 35) ? 0 : (pick < 75) ? int'($urandom_range(1, 5)) :
                 (pick < 90) ? int'($urandom_range(6, 65534)) : 65535;
            pick = $urandom_range(0, 99);
            dl = (pick < 50) ? 0 : (pick < 80) ? int'($urandom_range(1, 10)) :
                 int'($urandom_range(11, 65535));
            send_request(make_write($urandom_range(0, 15), ($urandom_range(0, 99) < 85),
                                    wd, hr, mn, iv, dl));
         end else begin
            // Advance the wall clock, mostly by about one minute
            pick = $urandom_range(0, 99);
            if (pick < 65)      wall_clock += $urandom_range(40, 90);
            else if (pick < 75) wall_clock += $urandom_range(0, 20);
            else if (pick < 85) wall_clock += $urandom_range(91, 200000);
            else if (pick < 93) wall_clock -= $urandom_range(1, 600);
            else                wall_clock = $urandom;
            cal_min  = int'((wall_clock / 60) % 60);
            cal_hour = int'((wall_clock / 3600) % 24);
            cal_wday = int'((wall_clock / 86400 + 4) % 7);
            if ($urandom_range(0, 99) < 10) begin
               cal_wday = $urandom_range(0, 6);
               cal_hour = $urandom_range(0, 23);
               cal_min  = $urandom_range(0, 59);
            end
            send_request(make_tick(wall_clock, cal_wday, cal_hour, cal_min));
         end
         items++;
      end
   endtask

   initial begin
      reset                     <= 1'b1;
      req_if.valid              <= 1'b0;
      req_if.op                 <= OP_WRITE;
      req_if.slot               <= '0;
      req_if.entry_on           <= 1'b0;
      req_if.entry_weekday      <= '0;
      req_if.entry_hour         <= '0;
      req_if.entry_minute       <= '0;
      req_if.entry_interval_min <= '0;
      req_if.entry_delay_min    <= '0;
      req_if.now_seconds        <= '0;
      req_if.now_weekday        <= '0;
      req_if.now_hour           <= '0;
      req_if.now_minute         <= '0;
      csr_if.valid              <= 1'b0;
      csr_if.start_time_seconds <= '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_one_shot_alarms();
      test_interval_alarms();
      test_start_after_now();
      test_fire_at_time_zero();

      wall_clock = $urandom_range(86400, 32'hF000_0000);
      test_random_traffic(0, 0, wall_clock - 32'd300);
      test_random_traffic(68, 0, 32'd0);
      test_random_traffic(0, 68, 32'hFFFF_FFFF);
      test_random_traffic(32, 32, wall_clock - $urandom_range(0, 3000));

      wait_until_drained();
      if (pending_fires.size() != 0)
         report_mismatch($sformatf("%0d expected fires never came", pending_fires.size()));
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/wats_pkg.sv
hw/rtl/wats_if.sv
hw/rtl/wats_ram.sv
hw/rtl/wats_min_div.sv
hw/rtl/wats_entry_eval.sv
hw/rtl/weekly_alarm_table_scheduler_top.sv
bench/tb_weekly_alarm_table_scheduler_top.sv
